### sv/ipw_pkg.sv
// Shared item types, timing constants and lookup functions for the IR pulse-width transmitter.
package ipw_pkg;

   localparam int CD_W   = 7;
   localparam int BITS_W = 4;
   localparam int DATA_W = 9;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SEND = 1'b1;

   localparam logic [CD_W-1:0] PRE_ON_TICKS   = 7'd3;
   localparam logic [CD_W-1:0] PRE_OFF_TICKS  = 7'd6;
   localparam logic [CD_W-1:0] SYNC_TICKS     = 7'd3;
   localparam logic [CD_W-1:0] BEACON_TICKS   = 7'd6;
   localparam logic [CD_W-1:0] BIT_GAP_TICKS  = 7'd2;
   localparam logic [CD_W-1:0] BIT_ZERO_TICKS = 7'd1;
   localparam logic [CD_W-1:0] BIT_ONE_TICKS  = 7'd2;

   localparam logic [1:0] COUNT_5 = 2'd0;
   localparam logic [1:0] COUNT_7 = 2'd1;
   localparam logic [1:0] COUNT_8 = 2'd2;
   localparam logic [1:0] COUNT_9 = 2'd3;

   localparam logic [1:0] PAUSE_SHORT  = 2'd0;
   localparam logic [1:0] PAUSE_MEDIUM = 2'd1;

   typedef struct packed {
      logic              op;
      logic              header_beacon;
      logic [1:0]        bit_count_code;
      logic [1:0]        pause_code;
      logic [DATA_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic led_on;
      logic accepted;
      logic busy_res;
   } rsp_type;

   function automatic logic [BITS_W-1:0] bit_count(input logic [1:0] code);
      logic [BITS_W-1:0] n;
      case (code)
         COUNT_5: n = 4'd5;
         COUNT_7: n = 4'd7;
         COUNT_8: n = 4'd8;
         COUNT_9: n = 4'd9;
         default: n = 4'd9;
      endcase
      return n;
   endfunction

   // Unused code saturates to the longest pause.
   function automatic logic [CD_W-1:0] pause_length(input logic [1:0] code);
      logic [CD_W-1:0] n;
      case (code)
         PAUSE_SHORT:  n = 7'd25;
         PAUSE_MEDIUM: n = 7'd56;
         default:      n = 7'd80;
      endcase
      return n;
   endfunction

endpackage

### sv/ipw_seq.sv
// Packet sequencer: state registers and the single-pass step for one item.
module ipw_seq import ipw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   output rsp_type result
);

   typedef enum logic [5:0] {
      PH_START    = 6'b000001,
      PH_PRE_GAP  = 6'b000010,
      PH_SYNC     = 6'b000100,
      PH_BIT_GAP  = 6'b001000,
      PH_BIT_MARK = 6'b010000,
      PH_CLOSE    = 6'b100000
   } phase_type;

   logic [CD_W-1:0]   countdown_ff, countdown_in;
   phase_type         phase_ff, phase_in;
   logic [BITS_W-1:0] bits_left_ff, bits_left_in;
   logic [DATA_W-1:0] shift_ff, shift_in;
   logic              beacon_ff, beacon_in;
   logic [1:0]        count_code_ff, count_code_in;
   logic [1:0]        pause_sel_ff, pause_sel_in;
   logic              sending_ff, sending_in;
   logic              led_ff, led_in;
   logic              accepted;
   logic [CD_W-1:0]   cd_dec;
   logic [BITS_W-1:0] bits_dec;

   assign cd_dec   = (countdown_ff != '0) ? countdown_ff - 7'd1 : countdown_ff;
   assign bits_dec = bits_left_ff - 4'd1;

   always_comb begin
      countdown_in  = countdown_ff;
      phase_in      = phase_ff;
      bits_left_in  = bits_left_ff;
      shift_in      = shift_ff;
      beacon_in     = beacon_ff;
      count_code_in = count_code_ff;
      pause_sel_in  = pause_sel_ff;
      sending_in    = sending_ff;
      led_in        = led_ff;
      accepted      = 1'b0;

      if (item.op == OP_TICK) begin
         countdown_in = cd_dec;
         if (sending_ff && cd_dec == '0) begin
            case (phase_ff)
               PH_START: begin
                  led_in       = 1'b1;
                  countdown_in = PRE_ON_TICKS;
                  phase_in     = PH_PRE_GAP;
               end
               PH_PRE_GAP: begin
                  led_in       = 1'b0;
                  countdown_in = PRE_OFF_TICKS;
                  phase_in     = PH_SYNC;
               end
               PH_SYNC: begin
                  led_in       = 1'b1;
                  countdown_in = beacon_ff ? BEACON_TICKS : SYNC_TICKS;
                  bits_left_in = bit_count(count_code_ff);
                  phase_in     = PH_BIT_GAP;
               end
               PH_BIT_GAP: begin
                  led_in       = 1'b0;
                  countdown_in = BIT_GAP_TICKS;
                  phase_in     = PH_BIT_MARK;
               end
               PH_BIT_MARK: begin
                  led_in       = 1'b1;
                  countdown_in = shift_ff[0] ? BIT_ONE_TICKS : BIT_ZERO_TICKS;
                  bits_left_in = bits_dec;
                  if (bits_dec != '0) begin
                     shift_in = shift_ff >> 1;
                     phase_in = PH_BIT_GAP;
                  end else begin
                     phase_in = PH_CLOSE;
                  end
               end
               default: begin
                  // closing pause: go idle, the countdown keeps running
                  countdown_in  = pause_length(pause_sel_ff);
                  led_in        = 1'b0;
                  sending_in    = 1'b0;
                  shift_in      = '0;
                  beacon_in     = 1'b0;
                  count_code_in = '0;
                  pause_sel_in  = '0;
                  phase_in      = PH_START;
               end
            endcase
         end
      end else if (!sending_ff) begin
         beacon_in     = item.header_beacon;
         count_code_in = item.bit_count_code;
         pause_sel_in  = item.pause_code;
         shift_in      = item.payload;
         phase_in      = PH_START;
         sending_in    = 1'b1;
         accepted      = 1'b1;
      end
   end

   assign result = '{led_on: led_in, accepted: accepted, busy_res: sending_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff  <= '0;
         phase_ff      <= PH_START;
         bits_left_ff  <= '0;
         shift_ff      <= '0;
         beacon_ff     <= 1'b0;
         count_code_ff <= '0;
         pause_sel_ff  <= '0;
         sending_ff    <= 1'b0;
         led_ff        <= 1'b0;
      end else if (step_en) begin
         countdown_ff  <= countdown_in;
         phase_ff      <= phase_in;
         bits_left_ff  <= bits_left_in;
         shift_ff      <= shift_in;
         beacon_ff     <= beacon_in;
         count_code_ff <= count_code_in;
         pause_sel_ff  <= pause_sel_in;
         sending_ff    <= sending_in;
         led_ff        <= led_in;
      end
   end

   a_led_needs_busy: assert property (@(posedge clock) disable iff (reset)
      led_ff |-> sending_ff)
      else $error("LED on while idle");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      (step_en && accepted) |-> !sending_ff)
      else $error("send taken while busy");

   a_tick_keeps_config: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.op == OP_TICK && sending_ff && phase_ff != PH_CLOSE) |=>
      (sending_ff && $stable(pause_sel_ff) && $stable(beacon_ff)))
      else $error("packet settings changed mid-packet");

endmodule

### sv/ir_pulse_width_tx_encoder.sv
// Top level: input register, packet sequencer and result register.
// An item passes from the input register into the result register.
// Throughput: one item per cycle unless stalled; the sequencer step is
// one pass of logic between the input register and the result register.
// rsp_stall while a result waits holds both registers and raises req_stall.
// Reset clears control state: LED off, idle, countdown zero, no item held.
module ir_pulse_width_tx_encoder import ipw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type step_rsp;
   logic    advance;
   logic    step_en;

   // hold everything while a result waits on a stalled consumer
   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign step_en   = advance && in_valid_ff;

   assign in_valid_in  = advance ? req_valid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   ipw_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_data_ff),
      .result  (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_data_ff  <= req_data;
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_step_yields_result: assert property (@(posedge clock) disable iff (reset)
      step_en |=> out_valid_ff)
      else $error("stepped item produced no result");

   a_accept_implies_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.accepted) |-> out_data_ff.busy_res)
      else $error("accepted send not reported busy");

   a_led_implies_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.led_on) |-> out_data_ff.busy_res)
      else $error("LED reported on while idle");

endmodule

### verif/ir_pulse_width_tx_encoder_tb.sv
// Self-checking testbench for the IR pulse-width transmitter: tick and send items in.
`timescale 1ns / 1ps

module ir_pulse_width_tx_encoder_tb import ipw_pkg::*; ();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 880;
   localparam int TAIL_ITEMS   = 100;
   localparam int HOLD_AT_ITEM = 300;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 8;

   localparam logic [1:0] PAUSE_UNUSED = 2'd3;

   localparam logic [CD_W-1:0] PAUSE_SHORT_TICKS  = 7'd25;
   localparam logic [CD_W-1:0] PAUSE_MEDIUM_TICKS = 7'd56;
   localparam logic [CD_W-1:0] PAUSE_LONG_TICKS   = 7'd80;

   typedef enum logic [5:0] {
      PH_LEAD_ON  = 6'b000001,
      PH_LEAD_OFF = 6'b000010,
      PH_SYNC     = 6'b000100,
      PH_BIT_GAP  = 6'b001000,
      PH_BIT_MARK = 6'b010000,
      PH_PAUSE    = 6'b100000
   } tx_phase_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   ir_pulse_width_tx_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Predicted transmitter state.
   logic [CD_W-1:0]   tx_cd;
   tx_phase_type      tx_phase;
   logic [BITS_W-1:0] tx_bits_left;
   logic [DATA_W-1:0] tx_shift;
   logic              tx_beacon;
   logic [1:0]        tx_code;
   logic [1:0]        tx_pause;
   logic              tx_busy;
   logic              tx_led;

   req_type pending[$];
   rsp_type rsp_due[$];

   bit req_fire;
   int items_taken;
   int packets_started;
   int results_checked;
   int errors;
   int cycles;
   int gap_left;
   int stall_left;
   int hold_left;
   bit hold_done;

   always #4 clock = ~clock;

   function automatic req_type random_item(input logic op);
      req_type it;
      it.op             = op;
      it.header_beacon  = 1'($urandom_range(0, 1));
      it.bit_count_code = 2'($urandom_range(0, 3));
      it.pause_code     = 2'($urandom_range(0, 3));
      it.payload        = 9'($urandom_range(0, 511));
      return it;
   endfunction

   function automatic void clear_packet();
      tx_led    = 1'b0;
      tx_busy   = 1'b0;
      tx_shift  = '0;
      tx_beacon = 1'b0;
      tx_code   = '0;
      tx_pause  = '0;
      tx_phase  = PH_LEAD_ON;
   endfunction

   function automatic rsp_type encode_step(input req_type it);
      rsp_type r;
      r.accepted = 1'b0;
      if (it.op == OP_TICK) begin
         if (tx_cd != '0) tx_cd = tx_cd - 7'd1;
         if (tx_busy && tx_cd == '0) begin
            case (tx_phase)
               PH_LEAD_ON: begin
                  tx_led   = 1'b1;
                  tx_cd    = PRE_ON_TICKS;
                  tx_phase = PH_LEAD_OFF;
               end
               PH_LEAD_OFF: begin
                  tx_led   = 1'b0;
                  tx_cd    = PRE_OFF_TICKS;
                  tx_phase = PH_SYNC;
               end
               PH_SYNC: begin
                  tx_led = 1'b1;
                  tx_cd  = tx_beacon ? BEACON_TICKS : SYNC_TICKS;
                  case (tx_code)
                     COUNT_5: tx_bits_left = 4'd5;
                     COUNT_7: tx_bits_left = 4'd7;
                     COUNT_8: tx_bits_left = 4'd8;
                     default: tx_bits_left = 4'd9;
                  endcase
                  tx_phase = PH_BIT_GAP;
               end
               PH_BIT_GAP: begin
                  tx_led   = 1'b0;
                  tx_cd    = BIT_GAP_TICKS;
                  tx_phase = PH_BIT_MARK;
               end
               PH_BIT_MARK: begin
                  tx_led       = 1'b1;
                  tx_cd        = tx_shift[0] ? BIT_ONE_TICKS : BIT_ZERO_TICKS;
                  tx_bits_left = tx_bits_left - 4'd1;
                  if (tx_bits_left != '0) begin
                     tx_shift = tx_shift >> 1;
                     tx_phase = PH_BIT_GAP;
                  end else begin
                     tx_phase = PH_PAUSE;
                  end
               end
               PH_PAUSE: begin
                  // closing pause runs while the block already reports idle
                  case (tx_pause)
                     PAUSE_SHORT:  tx_cd = PAUSE_SHORT_TICKS;
                     PAUSE_MEDIUM: tx_cd = PAUSE_MEDIUM_TICKS;
                     default:      tx_cd = PAUSE_LONG_TICKS;
                  endcase
                  clear_packet();
               end
               default: clear_packet();
            endcase
         end
      end else if (!tx_busy) begin
         // countdown and LED stay as they are
         tx_beacon  = it.header_beacon;
         tx_code    = it.bit_count_code;
         tx_pause   = it.pause_code;
         tx_shift   = it.payload;
         tx_phase   = PH_LEAD_ON;
         tx_busy    = 1'b1;
         r.accepted = 1'b1;
      end
      r.led_on   = tx_led;
      r.busy_res = tx_busy;
      return r;
   endfunction

   // Check results, then predict for the item taken at this edge.
   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type due_now;
      if (reset) begin
         tx_cd        = '0;
         tx_bits_left = '0;
         clear_packet();
         req_fire = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual %b", $time, rsp_data);
            end else begin
               want = rsp_due.pop_front();
               results_checked++;
               if (rsp_data.led_on !== want.led_on) begin
                  errors++;
                  $display("%0t: led_on expected %b, actual %b",
                           $time, want.led_on, rsp_data.led_on);
               end
               if (rsp_data.accepted !== want.accepted) begin
                  errors++;
                  $display("%0t: accepted expected %b, actual %b",
                           $time, want.accepted, rsp_data.accepted);
               end
               if (rsp_data.busy_res !== want.busy_res) begin
                  errors++;
                  $display("%0t: busy_res expected %b, actual %b",
                           $time, want.busy_res, rsp_data.busy_res);
               end
            end
         end
         req_fire = req_valid && !req_stall;
         if (req_fire) begin
            due_now = encode_step(req_data);
            if (due_now.accepted) packets_started++;
            rsp_due.push_back(due_now);
            items_taken++;
         end
      end
   end

   always @(negedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (req_valid && !req_fire) begin
         // hold the stalled item
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (pending.size() > TAIL_ITEMS && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         gap_left = $urandom_range(0, 3);
      end else if (pending.size() > 0) begin
         req_data  <= pending.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && items_taken >= HOLD_AT_ITEM) begin
         // long hold-off: let the pipeline fill and back up into the sender
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (pending.size() > TAIL_ITEMS && $urandom_range(0, 6) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycles, rsp_due.size());
         $display("ir_pulse_width_tx_encoder_tb: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      req_type it;
      int      n;
      int      run;

      // tick while idle with the countdown already at zero
      pending.push_back(random_item(OP_TICK));
      // widest packet: beacon, nine bits of ones, unused pause code
      it                = '0;
      it.op             = OP_SEND;
      it.header_beacon  = 1'b1;
      it.bit_count_code = COUNT_9;
      it.pause_code     = PAUSE_UNUSED;
      it.payload        = '1;
      pending.push_back(it);
      // request while busy, all other fields low: dropped
      it    = '0;
      it.op = OP_SEND;
      pending.push_back(it);
      repeat (20) pending.push_back(random_item(OP_TICK));

      // packets followed by runs of ticks; a short run leaves the next request
      // hitting a busy block, a long one lands it in the closing pause or idle
      n = 0;
      while (n < RANDOM_ITEMS) begin
         pending.push_back(random_item(OP_SEND));
         run = $urandom_range(10, 150);
         repeat (run)
            pending.push_back(random_item($urandom_range(0, 29) == 0 ? OP_SEND : OP_TICK));
         n += run + 1;
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_valid) @(posedge clock);
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items driven, %0d packets started, %0d results checked, %0d mismatches",
               items_taken, packets_started, results_checked, errors);
      $display("sender gaps, receiver stalls and one %0d-cycle hold-off exercised",
               HOLD_CYCLES);
      if (errors == 0) begin
         $display("ir_pulse_width_tx_encoder_tb: PASS");
      end else begin
         $display("ir_pulse_width_tx_encoder_tb: FAIL");
      end
      $finish;
   end

endmodule
